FILE: src/plpv_pkg.sv
// ----------------------------------------------------------------------------
// plpv_pkg: shared constants for the point-to-line projection block
// Default widths, the fixed width of the projection offset word and the
// queue depths used by the front and back parts.
// ----------------------------------------------------------------------------
package plpv_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // The offset along the line is kept as a 64-bit two's complement word.
  localparam int OFF_W = 64;

  // Width of one unsigned slice of t in the offset multiplication.
  localparam int MUL_CHUNK = 32;

  // Queue depths, powers of two.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

endpackage

FILE: src/plpv_fifo.sv
// ----------------------------------------------------------------------------
// plpv_fifo: small register queue
// First-in first-out queue in flip-flops with a combinational read of the
// oldest entry. DEPTH must be a power of two, at least two.
// ----------------------------------------------------------------------------
module plpv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

FILE: src/plpv_front.sv
// ----------------------------------------------------------------------------
// plpv_front: input side of the projection block
// Forms the line direction and point offset, the six products and the dot
// product and squared length, and flags a degenerate line. Three stages that
// all advance together while the queue behind has room.
// ----------------------------------------------------------------------------
module plpv_front #(
  parameter int COORD_WIDTH = plpv_pkg::COORD_WIDTH_DEF,
  localparam int DW    = COORD_WIDTH + 1,
  localparam int PRW   = 2 * DW,
  localparam int DOT_W = PRW + 2,
  localparam int LEN_W = PRW + 2,
  localparam int MID_W = 1 + DOT_W + LEN_W + 6 * DW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [3*COORD_WIDTH-1:0] point_i,
  input  logic [3*COORD_WIDTH-1:0] line_a_i,
  input  logic [3*COORD_WIDTH-1:0] line_b_i,
  output logic                     valid_o,
  output logic [MID_W-1:0]         data_o
);

  localparam int W = COORD_WIDTH;

  logic                  v0_q, v1_q, v2_q;
  logic signed [DW-1:0]  d0_q [3], e0_q [3], ap0_q [3];
  logic signed [DW-1:0]  d1_q [3], ap1_q [3];
  logic signed [PRW-1:0] pde_q [3], pdd_q [3];
  logic [3*DW-1:0]       d2_q, ap2_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [LEN_W-1:0]      len2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d0_q[i]  <= DW'($signed(line_b_i[i*W +: W])) - DW'($signed(line_a_i[i*W +: W]));
        e0_q[i]  <= DW'($signed(point_i[i*W +: W])) - DW'($signed(line_a_i[i*W +: W]));
        ap0_q[i] <= DW'($signed(line_a_i[i*W +: W])) - DW'($signed(point_i[i*W +: W]));
        pde_q[i] <= d0_q[i] * e0_q[i];
        pdd_q[i] <= d0_q[i] * d0_q[i];
        d1_q[i]  <= d0_q[i];
        ap1_q[i] <= ap0_q[i];
        d2_q[i*DW +: DW]  <= d1_q[i];
        ap2_q[i*DW +: DW] <= ap1_q[i];
      end
      dot_q  <= DOT_W'(pde_q[0]) + DOT_W'(pde_q[1]) + DOT_W'(pde_q[2]);
      len2_q <= LEN_W'(pdd_q[0]) + LEN_W'(pdd_q[1]) + LEN_W'(pdd_q[2]);
    end
  end

  assign valid_o = v2_q;
  assign data_o  = {(len2_q == '0), dot_q, len2_q, d2_q, ap2_q};

endmodule

FILE: src/plpv_divider.sv
// ----------------------------------------------------------------------------
// plpv_divider: pipelined restoring divider
// One quotient bit per stage, unsigned. Side data travels alongside so that
// the result leaves with everything the later stages need.
// ----------------------------------------------------------------------------
module plpv_divider #(
  parameter int NUM_W  = 84,
  parameter int DEN_W  = 68,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q    [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              pv;
    logic [NUM_W-1:0]  pnum;
    logic [DEN_W-1:0]  prem, pden;
    logic [SIDE_W-1:0] pside;
    logic [DEN_W:0]    sh, diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign pv    = valid_i;
      assign pnum  = num_i;
      assign prem  = '0;
      assign pden  = den_i;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[s-1];
      assign pnum  = num_q[s-1];
      assign prem  = rem_q[s-1];
      assign pden  = den_q[s-1];
      assign pside = side_q[s-1];
    end

    assign sh   = {prem, pnum[NUM_W-1]};
    assign diff = sh - {1'b0, pden};
    assign ge   = (sh >= {1'b0, pden});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= {pnum[NUM_W-2:0], ge};
        rem_q[s]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        den_q[s]  <= pden;
        side_q[s] <= pside;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quot_o  = num_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

FILE: src/plpv_back.sv
// ----------------------------------------------------------------------------
// plpv_back: execution side of the projection block
// Takes classified items from the middle queue, divides for t, scales the
// line direction by t, adds the point-to-line offset and saturates.
// ----------------------------------------------------------------------------
module plpv_back #(
  parameter int COORD_WIDTH = plpv_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = plpv_pkg::FRAC_BITS_DEF,
  localparam int DW    = COORD_WIDTH + 1,
  localparam int PRW   = 2 * DW,
  localparam int DOT_W = PRW + 2,
  localparam int LEN_W = PRW + 2,
  localparam int MID_W = 1 + DOT_W + LEN_W + 6 * DW,
  localparam int RES_W = 3 * COORD_WIDTH + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             mid_empty_i,
  input  logic [MID_W-1:0] mid_data_i,
  output logic             mid_pop_o,
  output logic             valid_o,
  output logic [RES_W-1:0] data_o
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int OFF_W  = plpv_pkg::OFF_W;
  localparam int CH     = plpv_pkg::MUL_CHUNK;
  localparam int NUM_W  = DOT_W + F;
  localparam int PW     = OFF_W + F;
  localparam int XW     = (NUM_W + 1 > PW) ? NUM_W + 1 : PW;
  localparam int NCH    = (PW + CH - 1) / CH;
  localparam int PPW    = CH + 1 + DW;
  localparam int SIDE_W = 2 + 6 * DW;

  // Middle queue layout
  logic                    m_deg;
  logic signed [DOT_W-1:0] m_dot;
  logic [LEN_W-1:0]        m_len2;
  logic [6*DW-1:0]         m_vec;

  assign {m_deg, m_dot, m_len2, m_vec} = mid_data_i;
  assign mid_pop_o = en_i && !mid_empty_i;

  // Stage B0: sign and magnitude of the dot product
  logic              b0_v_q;
  logic [NUM_W-1:0]  b0_num_q;
  logic [LEN_W-1:0]  b0_den_q;
  logic [SIDE_W-1:0] b0_side_q;
  logic [DOT_W-1:0]  mag;

  assign mag = m_dot[DOT_W-1] ? DOT_W'(-m_dot) : DOT_W'(m_dot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
    end else if (en_i) begin
      b0_v_q <= !mid_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b0_num_q  <= {mag, {F{1'b0}}};
      b0_den_q  <= m_len2;
      b0_side_q <= {m_deg, m_dot[DOT_W-1], m_vec};
    end
  end

  logic              dv;
  logic [NUM_W-1:0]  quot;
  logic [SIDE_W-1:0] dside;

  plpv_divider #(
    .NUM_W (NUM_W),
    .DEN_W (LEN_W),
    .SIDE_W(SIDE_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(b0_v_q),
    .num_i  (b0_num_q),
    .den_i  (b0_den_q),
    .side_i (b0_side_q),
    .valid_o(dv),
    .quot_o (quot),
    .side_o (dside)
  );

  // Stage B1: signed t, low PW bits
  logic                  s_deg, s_tneg;
  logic [6*DW-1:0]       s_vec;
  logic signed [NUM_W:0] ts;
  logic signed [XW-1:0]  tx;

  assign {s_deg, s_tneg, s_vec} = dside;
  assign ts = s_tneg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign tx = XW'(ts);

  logic                  b1_v_q, b1_deg_q;
  logic [NCH*CH-1:0]     b1_t_q;
  logic [6*DW-1:0]       b1_vec_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_t_q   <= (NCH*CH)'(tx[PW-1:0]);
      b1_deg_q <= s_deg;
      b1_vec_q <= s_vec;
    end
  end

  // Stage B2: partial products of t slices by each direction component
  logic                  b2_v_q, b2_deg_q;
  logic signed [PPW-1:0] pp_q [3][NCH];
  logic [3*DW-1:0]       b2_ap_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NCH; k++) begin
          pp_q[i][k] <= $signed({1'b0, b1_t_q[k*CH +: CH]})
                        * $signed(b1_vec_q[(3+i)*DW +: DW]);
        end
      end
      b2_ap_q  <= b1_vec_q[3*DW-1:0];
      b2_deg_q <= b1_deg_q;
    end
  end

  // Stage B3: offset along the line, floor of the product over 2^F
  logic                  b3_v_q, b3_deg_q;
  logic [OFF_W-1:0]      off_q [3];
  logic [3*DW-1:0]       b3_ap_q;
  logic [PW-1:0]         psum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = '0;
      for (int k = 0; k < NCH; k++) begin
        psum[i] = psum[i] + (PW'(pp_q[i][k]) << (k * CH));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= psum[i][PW-1:F];
      end
      b3_ap_q  <= b2_ap_q;
      b3_deg_q <= b2_deg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
    end else if (en_i) begin
      b1_v_q <= dv;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
    end
  end

  // Final add and saturation, straight into the result queue
  logic [OFF_W-1:0] mv  [3];
  logic [W-1:0]     res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mv[i] = off_q[i] + OFF_W'($signed(b3_ap_q[i*DW +: DW]));
      if (mv[i][OFF_W-1:W-1] == '0 || mv[i][OFF_W-1:W-1] == '1) begin
        res[i] = mv[i][W-1:0];
      end else if (mv[i][OFF_W-1]) begin
        res[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res[i] = {1'b0, {(W-1){1'b1}}};
      end
      if (b3_deg_q) res[i] = '0;
    end
  end

  assign valid_o = b3_v_q && en_i;
  assign data_o  = {b3_deg_q, res[2], res[1], res[0]};

endmodule

FILE: src/point_line_projection_vector.sv
// ----------------------------------------------------------------------------
// point_line_projection_vector: move vector from a 3D point to its projection
// Top level with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Each transfer in carries a point P and two line points A and B in signed
// fixed point; each transfer out carries the vector that moves P onto its
// perpendicular projection on line AB, saturated to the coordinate range,
// plus a flag that is set (with a zero vector) when A equals B. The block
// takes one item per cycle and keeps many in flight, so a steady stream runs
// at one item per clock as long as the consumer pops each cycle. Latency from
// push to the result appearing, at the default Q16.16 as at other widths, is
// set almost entirely by the pipelined divider that produces t, which retires
// one quotient bit per stage. The front part (differences, products, dot
// product and squared length) feeds a four-entry queue; the back part
// (divider, offset multiply, saturation) drains it into a two-entry result
// queue. full rises only when the middle queue fills, and the back part
// stalls only when the result queue is full.
// ----------------------------------------------------------------------------
module point_line_projection_vector #(
  parameter int COORD_WIDTH = plpv_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = plpv_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_WIDTH-1:0] point_x_i,
  input  logic [COORD_WIDTH-1:0] point_y_i,
  input  logic [COORD_WIDTH-1:0] point_z_i,
  input  logic [COORD_WIDTH-1:0] line_a_x_i,
  input  logic [COORD_WIDTH-1:0] line_a_y_i,
  input  logic [COORD_WIDTH-1:0] line_a_z_i,
  input  logic [COORD_WIDTH-1:0] line_b_x_i,
  input  logic [COORD_WIDTH-1:0] line_b_y_i,
  input  logic [COORD_WIDTH-1:0] line_b_z_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [COORD_WIDTH-1:0] move_x_o,
  output logic [COORD_WIDTH-1:0] move_y_o,
  output logic [COORD_WIDTH-1:0] move_z_o,
  output logic                   degenerate_line_o
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PRW   = 2 * DW;
  localparam int MID_W = 1 + 2 * (PRW + 2) + 6 * DW;
  localparam int RES_W = 3 * COORD_WIDTH + 1;

  // The front advances whenever the middle queue has room, so full is
  // simply that queue's full flag.
  logic             mid_full, mid_empty, mid_pop, front_valid;
  logic [MID_W-1:0] front_data, mid_rdata;
  logic             out_full, back_valid;
  logic [RES_W-1:0] back_data, out_rdata;

  assign full = mid_full;

  plpv_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!mid_full),
    .valid_i (push && !mid_full),
    .point_i ({point_z_i, point_y_i, point_x_i}),
    .line_a_i({line_a_z_i, line_a_y_i, line_a_x_i}),
    .line_b_i({line_b_z_i, line_b_y_i, line_b_x_i}),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  plpv_fifo #(
    .WIDTH(MID_W),
    .DEPTH(plpv_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .wdata_i(front_data),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );

  // The whole back pipeline holds while the result queue is full.
  plpv_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (!out_full),
    .mid_empty_i(mid_empty),
    .mid_data_i (mid_rdata),
    .mid_pop_o  (mid_pop),
    .valid_o    (back_valid),
    .data_o     (back_data)
  );

  plpv_fifo #(
    .WIDTH(RES_W),
    .DEPTH(plpv_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_valid),
    .wdata_i(back_data),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty)
  );

  assign {degenerate_line_o, move_z_o, move_y_o, move_x_o} = out_rdata;

endmodule

FILE: src/plpv_checker.sv
// ----------------------------------------------------------------------------
// plpv_checker: port-level checks for the projection block
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module plpv_checker #(
  parameter int COORD_WIDTH = plpv_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic [COORD_WIDTH-1:0] move_x_o,
  input logic [COORD_WIDTH-1:0] move_y_o,
  input logic [COORD_WIDTH-1:0] move_z_o,
  input logic                   degenerate_line_o
);

  // Items taken in but not yet popped.
  logic [15:0] pending_q;
  logic        in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 16'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 16'd1;
    end
  end

  a_no_invented_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != '0))
    else $error("result shown with no item outstanding");

  a_degenerate_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && degenerate_line_o) |->
      (move_x_o == '0 && move_y_o == '0 && move_z_o == '0))
    else $error("degenerate line with nonzero vector");

  a_result_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result withdrawn");

  a_result_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(move_x_o) && $stable(move_y_o) &&
                          $stable(move_z_o) && $stable(degenerate_line_o)))
    else $error("waiting result changed");

endmodule

bind point_line_projection_vector plpv_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_plpv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .push             (push),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .move_x_o         (move_x_o),
  .move_y_o         (move_y_o),
  .move_z_o         (move_z_o),
  .degenerate_line_o(degenerate_line_o)
);

FILE: tb/sv/tb_point_line_projection_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_line_projection_vector: self-checking bench for the projection
// Items carrying a point and two line points are pushed through the block in
// bursts, and each popped move vector is checked against an exact wide-integer
// prediction that the bench computes when the item is accepted.
// ----------------------------------------------------------------------------
module tb_point_line_projection_vector;

  localparam int CW = plpv_pkg::COORD_WIDTH_DEF;
  localparam int FB = plpv_pkg::FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1130;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [CW-1:0] coord_t;

  // One query: the point, then line point A, then line point B.
  typedef struct packed {
    coord_t px, py, pz;
    coord_t ax, ay, az;
    coord_t bx, by, bz;
  } query_t;

  typedef struct packed {
    coord_t mx, my, mz;
    logic   degen;
  } move_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  query_t drive_q = '0;
  logic [CW-1:0] move_x_o, move_y_o, move_z_o;
  logic degenerate_line_o;

  query_t pending_queries[$];
  move_t  expected_moves[$];
  int     mismatch_count = 0;
  int     transfers_in = 0;
  int     transfers_out = 0;
  int     degenerate_seen = 0;
  int     idle_cycles = 0;
  bit     hold_request = 1'b0;
  bit     hold_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  point_line_projection_vector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .point_x_i        (drive_q.px),
    .point_y_i        (drive_q.py),
    .point_z_i        (drive_q.pz),
    .line_a_x_i       (drive_q.ax),
    .line_a_y_i       (drive_q.ay),
    .line_a_z_i       (drive_q.az),
    .line_b_x_i       (drive_q.bx),
    .line_b_y_i       (drive_q.by),
    .line_b_z_i       (drive_q.bz),
    .empty            (empty),
    .pop              (pop),
    .move_x_o         (move_x_o),
    .move_y_o         (move_y_o),
    .move_z_o         (move_z_o),
    .degenerate_line_o(degenerate_line_o)
  );

  // Clamp a wide signed value into the coordinate range.
  function automatic coord_t clamp_coord(logic signed [255:0] v);
    logic signed [255:0] hi_bound, lo_bound;
    hi_bound = (256'sd1 <<< (CW - 1)) - 1;
    lo_bound = -(256'sd1 <<< (CW - 1));
    if (v > hi_bound) return hi_bound[CW-1:0];
    if (v < lo_bound) return lo_bound[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Exact projection move vector. The ratio t is truncated toward zero and
  // kept in a 128-bit word; its product with each direction component keeps
  // the low 128 bits, then shifts right arithmetically (floor). Only the low
  // 64 bits of the shifted offset take part in the final sum.
  function automatic move_t project_move(query_t q);
    logic signed [255:0] p[3], a[3], d[3];
    logic signed [255:0] dot_sum, len_sq, ratio, prod, offset, total;
    logic signed [127:0] ratio_w, prod_w, off_w;
    logic signed [63:0]  off_lo;
    move_t r;
    p = '{256'(q.px), 256'(q.py), 256'(q.pz)};
    a = '{256'(q.ax), 256'(q.ay), 256'(q.az)};
    d = '{256'(q.bx) - 256'(q.ax), 256'(q.by) - 256'(q.ay), 256'(q.bz) - 256'(q.az)};
    dot_sum = 0;
    len_sq = 0;
    for (int i = 0; i < 3; i++) begin
      dot_sum += d[i] * (p[i] - a[i]);
      len_sq += d[i] * d[i];
    end
    r = '0;
    if (len_sq == 0) begin
      r.degen = 1'b1;
      return r;
    end
    ratio = (dot_sum <<< FB) / len_sq;
    ratio_w = ratio[127:0];
    for (int i = 0; i < 3; i++) begin
      prod = 256'(ratio_w) * d[i];
      prod_w = prod[127:0];
      off_w = prod_w >>> FB;
      off_lo = off_w[63:0];
      offset = 256'(off_lo);
      total = a[i] + offset - p[i];
      if (i == 0) r.mx = clamp_coord(total);
      else if (i == 1) r.my = clamp_coord(total);
      else r.mz = clamp_coord(total);
    end
    return r;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return {1'b0, {(CW - 1){1'b1}}};
      2: return {1'b1, {(CW - 1){1'b0}}};
      3: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< FB;
      default: return coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    q = {random_coord(), random_coord(), random_coord(), random_coord(), random_coord(),
         random_coord(), random_coord(), random_coord(), random_coord()};
    // Some lines collapse to a point, partly or fully.
    if ($urandom_range(0, 19) == 0) {q.bx, q.by, q.bz} = {q.ax, q.ay, q.az};
    else if ($urandom_range(0, 9) == 0) q.bx = q.ax;
    return q;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_moves.push_back(project_move(drive_q));
        transfers_in++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_queries.size() > 0) begin
          drive_q <= pending_queries.pop_front();
          push <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pops on its own stall pattern, with one long hold-off on request.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        transfers_out++;
        if (expected_moves.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected transfer out: %h %h %h %b",
                                             move_x_o, move_y_o, move_z_o, degenerate_line_o);
        end else begin
          move_t want;
          want = expected_moves.pop_front();
          if (degenerate_line_o) degenerate_seen++;
          if (move_x_o !== want.mx || move_y_o !== want.my || move_z_o !== want.mz ||
              degenerate_line_o !== want.degen) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                       want.mx, want.my, want.mz, want.degen,
                       move_x_o, move_y_o, move_z_o, degenerate_line_o);
          end
        end
      end
      if (hold_request && !hold_done) begin
        if (hold_left == 0) hold_left = HOLD_CYCLES;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          default: pop <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("point_line_projection_vector verification failed");
        $finish;
      end
    end
  end

  initial begin
    query_t q;
    // Directed: extremes, degenerate lines, a point on the line and axis cases.
    q = '0;
    pending_queries.push_back(q);
    q.bx = coord_t'(1 << FB);
    pending_queries.push_back(q);
    q.py = coord_t'(3 << FB);
    q.px = coord_t'(2 << FB);
    pending_queries.push_back(q);
    q = '1;
    pending_queries.push_back(q);
    q = {9{1'b0, {(CW - 1){1'b1}}}};
    pending_queries.push_back(q);
    q = {9{1'b1, {(CW - 1){1'b0}}}};
    pending_queries.push_back(q);
    q = {{3{1'b0, {(CW - 1){1'b1}}}}, {3{1'b1, {(CW - 1){1'b0}}}},
         {3{1'b0, {(CW - 1){1'b1}}}}};
    pending_queries.push_back(q);
    q = {{3{1'b1, {(CW - 1){1'b0}}}}, {3{1'b0, {(CW - 1){1'b1}}}},
         {3{1'b1, {(CW - 1){1'b0}}}}};
    pending_queries.push_back(q);
    // The smallest possible direction with a huge point offset gives a large t.
    q = '0;
    q.bz = coord_t'(1);
    q.pz = {1'b0, {(CW - 1){1'b1}}};
    q.px = {1'b1, {(CW - 1){1'b0}}};
    pending_queries.push_back(q);
    q.pz = {1'b1, {(CW - 1){1'b0}}};
    pending_queries.push_back(q);
    // Negative t, truncated toward zero, with the offset rounded toward negative infinity.
    q = '0;
    q.bx = coord_t'(3);
    q.by = coord_t'(-7);
    q.px = coord_t'(-5);
    q.py = coord_t'(11);
    q.pz = coord_t'(13);
    pending_queries.push_back(q);
    for (int i = 0; i < 12; i++) pending_queries.push_back(random_query());
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_queries.push_back(random_query());
      // Midway, let the receiver hold off while the sender keeps offering.
      if (i == RANDOM_ITEMS / 2) begin
        while (pending_queries.size() >= 8) @(posedge clk_i);
        hold_request = 1'b1;
        for (int j = 0; j < 300; j++) pending_queries.push_back(random_query());
        i += 300;
      end
    end

    while (pending_queries.size() != 0 || push) @(posedge clk_i);
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d transfers in and %0d out, %0d degenerate lines, one long stall.",
             transfers_in, transfers_out, degenerate_seen);
    if (mismatch_count == 0 && expected_moves.size() == 0) begin
      $display("point_line_projection_vector verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("point_line_projection_vector verification failed");
    end
    $finish;
  end

endmodule
